// ----- hw/rtl/cms_pkg.sv -----
// Shared types and constants for the count-min frequency sketch.
// No dependencies; imported by cms_hash, the sketch unit, checker and bench.
package cms_pkg;

    localparam int ROWS = 4;
    localparam int MIN_WIDTH_LOG2 = 10;
    localparam logic [3:0] COUNTER_MAX = 4'd15;

    localparam logic CFG_WIDTH_LOG2 = 1'b0;
    localparam logic CFG_AGING_THRESHOLD = 1'b1;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_ESTIMATE = 1'b1;

    localparam logic [63:0] KEY_MUL [4] = '{
        64'hff51afd7ed558ccd, 64'hc4ceb9fe1a85ec53,
        64'h9e3779b97f4a7c15, 64'hbf58476d1ce4e5b9};

    localparam logic [63:0] ROW_MUL [ROWS] = '{
        64'h9e3779b97f4a7c15, 64'hc2b2ae3d27d4eb4f,
        64'h165667b19e3779f9, 64'hff51afd7ed558ccd};

    typedef struct packed {
        logic        operation;
        logic [31:0] key_word0;
        logic [31:0] key_word1;
        logic [31:0] key_word2;
        logic [31:0] key_word3;
    } in_word_t;

    typedef struct packed {
        logic [3:0] frequency;
        logic       aged;
    } out_word_t;

endpackage

// ----- hw/rtl/count_min_frequency_sketch_unit.sv -----
// Top level of the count-min frequency sketch: control, counter rows, config.
// Depends on cms_pkg and cms_hash.
//
//   channel  | signals                           | direction
//   item     | item_valid, item_ready, item      | in
//   result   | result_valid, result_ready, result| out
//   config   | cfg_we, cfg_index, cfg_data       | in
//
// An item passes four hash pipeline stages, one memory read, one read-modify-write
// and the result register before its result word appears. The next item is taken
// only once the block is back in S_IDLE, so it does not overlap the one before.
// A record that ages adds a halving sweep over all addresses of all rows at once.
// After reset a clearing pass over every address runs before any item is taken.
// A stalled result holds the block after its next item.
module count_min_frequency_sketch_unit
    import cms_pkg::*;
#(
    parameter int MAX_WIDTH_LOG2 = 14
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_word_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_word_t result,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [19:0] cfg_data
);

    localparam int AW = MAX_WIDTH_LOG2;
    localparam int DEPTH = 1 << MAX_WIDTH_LOG2;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HASH, S_READ, S_MODIFY, S_AGE, S_DONE
    } state_t;

    state_t      state_reg;
    logic [1:0]  wait_reg;
    logic [AW-1:0] sweep_reg;
    logic        sweep_rd_reg;
    logic        age_wr_reg;
    logic [AW-1:0] age_addr_reg;
    logic [3:0]  width_log2_reg;
    logic [19:0] threshold_reg;
    logic [19:0] sample_reg;
    logic        op_reg;
    logic [31:0] key_reg [4];
    logic [3:0]  freq_reg;
    logic        aged_reg;
    logic        result_valid_reg;
    out_word_t   result_reg;

    logic [3:0]  mem [ROWS][DEPTH];
    logic [3:0]  rdata_reg [ROWS];

    logic          mem_we;
    logic [AW-1:0] raddr [ROWS];
    logic [AW-1:0] waddr [ROWS];
    logic [3:0]    wdata [ROWS];

    logic [AW-1:0] row_index [ROWS];
    logic [AW-1:0] mask;
    logic [4:0]    eff_width;
    logic [3:0]    min_count;
    logic [20:0]   count_inc;
    logic          will_age;
    logic          res_load;

    always_comb
    begin
        if (width_log2_reg < 4'(MIN_WIDTH_LOG2))
            eff_width = 5'(MIN_WIDTH_LOG2);
        else if (32'(width_log2_reg) > MAX_WIDTH_LOG2)
            eff_width = 5'(MAX_WIDTH_LOG2);
        else
            eff_width = {1'b0, width_log2_reg};
        for (int b = 0; b < AW; b++)
        begin
            mask[b] = (5'(b) < eff_width);
        end
    end

    cms_hash #(
        .MAX_WIDTH_LOG2(MAX_WIDTH_LOG2)
    ) u_hash (
        .clk(clk),
        .key_words(key_reg),
        .mask(mask),
        .row_index(row_index)
    );

    always_comb
    begin
        min_count = COUNTER_MAX;
        for (int r = 0; r < ROWS; r++)
        begin
            if (rdata_reg[r] < min_count)
                min_count = rdata_reg[r];
        end
        count_inc = {1'b0, sample_reg} + 21'd1;
        will_age = count_inc >= {1'b0, threshold_reg};
    end

    // Memory port control: item read-modify-write, aging sweep, reset clear.
    always_comb
    begin
        mem_we = 1'b0;
        for (int r = 0; r < ROWS; r++)
        begin
            raddr[r] = row_index[r];
            waddr[r] = row_index[r];
            wdata[r] = (rdata_reg[r] == COUNTER_MAX) ? rdata_reg[r] : rdata_reg[r] + 4'd1;
        end
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                for (int r = 0; r < ROWS; r++)
                begin
                    waddr[r] = sweep_reg;
                    wdata[r] = '0;
                end
            end
            S_MODIFY:
            begin
                mem_we = (op_reg == OP_RECORD);
            end
            S_AGE:
            begin
                mem_we = age_wr_reg;
                for (int r = 0; r < ROWS; r++)
                begin
                    raddr[r] = sweep_reg;
                    waddr[r] = age_addr_reg;
                    wdata[r] = rdata_reg[r] >> 1;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            if (mem_we)
                mem[r][waddr[r]] <= wdata[r];
            rdata_reg[r] <= mem[r][raddr[r]];
        end
    end

    assign item_ready = (state_reg == S_IDLE);
    assign res_load = (state_reg == S_DONE) && (!result_valid_reg || result_ready);
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            op_reg <= item.operation;
            key_reg[0] <= item.key_word0;
            key_reg[1] <= item.key_word1;
            key_reg[2] <= item.key_word2;
            key_reg[3] <= item.key_word3;
        end
        if (res_load)
        begin
            result_reg.frequency <= freq_reg;
            result_reg.aged <= aged_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            wait_reg <= '0;
            sweep_reg <= '0;
            sweep_rd_reg <= 1'b0;
            age_wr_reg <= 1'b0;
            age_addr_reg <= '0;
            width_log2_reg <= 4'd10;
            threshold_reg <= 20'd128;
            sample_reg <= '0;
            freq_reg <= '0;
            aged_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIDTH_LOG2)
                    width_log2_reg <= cfg_data[3:0];
                else
                    threshold_reg <= cfg_data;
            end

            if (res_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;

            case (state_reg)
                S_CLEAR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (&sweep_reg)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        wait_reg <= '0;
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    wait_reg <= wait_reg + 2'd1;
                    if (&wait_reg)
                        state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_MODIFY;
                end
                S_MODIFY:
                begin
                    aged_reg <= 1'b0;
                    if (op_reg == OP_ESTIMATE)
                    begin
                        freq_reg <= min_count;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        freq_reg <= '0;
                        if (will_age)
                        begin
                            sample_reg <= count_inc[20:1];
                            aged_reg <= 1'b1;
                            sweep_reg <= '0;
                            sweep_rd_reg <= 1'b1;
                            age_wr_reg <= 1'b0;
                            state_reg <= S_AGE;
                        end
                        else
                        begin
                            sample_reg <= count_inc[19:0];
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_AGE:
                begin
                    // Read one address while writing back the one read before.
                    age_wr_reg <= sweep_rd_reg;
                    age_addr_reg <= sweep_reg;
                    if (sweep_rd_reg)
                    begin
                        sweep_reg <= sweep_reg + 1'b1;
                        if (&sweep_reg)
                            sweep_rd_reg <= 1'b0;
                    end
                    else if (age_wr_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (res_load)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/cms_hash.sv -----
// Four-stage hash and row index pipeline of the frequency sketch.
// Depends on cms_pkg for the multiplier constants and the row count.
module cms_hash
    import cms_pkg::*;
#(
    parameter int MAX_WIDTH_LOG2 = 14
) (
    input  logic                      clk,
    input  logic [31:0]               key_words [4],
    input  logic [MAX_WIDTH_LOG2-1:0] mask,
    output logic [MAX_WIDTH_LOG2-1:0] row_index [ROWS]
);

    // Each 32x64 product mod 2^64 is a full low product plus a truncated high one.
    logic [63:0] lo_prod_reg [4];
    logic [31:0] hi_prod_reg [4];
    logic [63:0] hash_reg;
    logic [31:0] rp0_reg [ROWS];
    logic [31:0] rp1_reg [ROWS];
    logic [31:0] rp2_reg [ROWS];

    logic [63:0] lo_prod_next [4];
    logic [63:0] hi_full [4];
    logic [63:0] hash_next;
    logic [63:0] rp0_full [ROWS];
    logic [63:0] rp1_full [ROWS];
    logic [63:0] rp2_full [ROWS];
    logic [31:0] row_sum [ROWS];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lo_prod_next[i] = key_words[i] * KEY_MUL[i][31:0];
            hi_full[i] = key_words[i] * KEY_MUL[i][63:32];
        end
        hash_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            hash_next = hash_next ^ (lo_prod_reg[i] + {hi_prod_reg[i], 32'd0});
        end
        for (int r = 0; r < ROWS; r++)
        begin
            rp0_full[r] = hash_reg[31:0] * ROW_MUL[r][31:0];
            rp1_full[r] = hash_reg[31:0] * ROW_MUL[r][63:32];
            rp2_full[r] = hash_reg[63:32] * ROW_MUL[r][31:0];
            row_sum[r] = rp0_reg[r] + rp1_reg[r] + rp2_reg[r];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            lo_prod_reg[i] <= lo_prod_next[i];
            hi_prod_reg[i] <= hi_full[i][31:0];
        end
        hash_reg <= hash_next;
        for (int r = 0; r < ROWS; r++)
        begin
            rp0_reg[r] <= rp0_full[r][63:32];
            rp1_reg[r] <= rp1_full[r][31:0];
            rp2_reg[r] <= rp2_full[r][31:0];
            row_index[r] <= row_sum[r][MAX_WIDTH_LOG2-1:0] & mask;
        end
    end

endmodule

// ----- dv/count_min_frequency_sketch_unit_checker.sv -----
// Checker for the count-min frequency sketch: watches the item, result and config ports,
// predicts every result word and compares it. Depends on cms_pkg.
`timescale 1ns / 100ps

module count_min_frequency_sketch_unit_checker
    import cms_pkg::*;
#(
    parameter int MAX_WIDTH_LOG2 = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  in_word_t    item,
    input  logic        result_valid,
    input  logic        result_ready,
    input  out_word_t   result,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          results_seen,
    output int          agings
);

    localparam int STORE_DEPTH = ROWS << MAX_WIDTH_LOG2;

    // Halving is applied lazily: each counter remembers how many halvings had
    // happened when it was last written, and is shifted on its next read.
    logic [3:0]  counts [STORE_DEPTH];
    int unsigned stamps [STORE_DEPTH];
    int unsigned halvings;
    logic [20:0] sample_count;
    logic [3:0]  width_log2;
    logic [19:0] aging_threshold;
    out_word_t   expected_words [$];

    initial
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            counts[i] = '0;
            stamps[i] = 0;
        end
        halvings = 0;
        errors = 0;
        pending = 0;
        results_seen = 0;
        agings = 0;
    end

    function automatic logic [3:0] counter_value(int unsigned slot);
        int unsigned shift;
        shift = halvings - stamps[slot];
        return (shift >= 4) ? 4'd0 : counts[slot] >> shift;
    endfunction

    function automatic out_word_t sketch_update(in_word_t w);
        logic [63:0] h;
        logic [63:0] mixed;
        logic [31:0] mask;
        int unsigned slot;
        logic [3:0]  c;
        logic [3:0]  least;
        int          wl;
        out_word_t   r;
        h = '0;
        h ^= 64'(w.key_word0) * KEY_MUL[0];
        h ^= 64'(w.key_word1) * KEY_MUL[1];
        h ^= 64'(w.key_word2) * KEY_MUL[2];
        h ^= 64'(w.key_word3) * KEY_MUL[3];
        wl = width_log2;
        if (wl < MIN_WIDTH_LOG2)
            wl = MIN_WIDTH_LOG2;
        if (wl > MAX_WIDTH_LOG2)
            wl = MAX_WIDTH_LOG2;
        mask = (32'd1 << wl) - 1;
        least = COUNTER_MAX;
        r = '0;
        for (int d = 0; d < ROWS; d++)
        begin
            mixed = h * ROW_MUL[d];
            slot = (d << MAX_WIDTH_LOG2) + (mixed[63:32] & mask);
            c = counter_value(slot);
            if (w.operation == OP_ESTIMATE)
            begin
                if (c < least)
                    least = c;
            end
            else
            begin
                counts[slot] = (c < COUNTER_MAX) ? c + 4'd1 : c;
                stamps[slot] = halvings;
            end
        end
        if (w.operation == OP_ESTIMATE)
            r.frequency = least;
        else
        begin
            sample_count = sample_count + 21'd1;
            if (sample_count >= {1'b0, aging_threshold})
            begin
                halvings++;
                sample_count = sample_count >> 1;
                r.aged = 1'b1;
            end
            sample_count[20] = 1'b0;
        end
        return r;
    endfunction

    task automatic report(string what, logic [3:0] got, logic [3:0] want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            sample_count = '0;
            width_log2 = 4'd10;
            aging_threshold = 20'd128;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIDTH_LOG2)
                    width_log2 = cfg_data[3:0];
                else
                    aging_threshold = cfg_data;
            end
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result word with nothing expected", $realtime);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (result.frequency !== want.frequency)
                        report("frequency", result.frequency, want.frequency);
                    if (result.aged !== want.aged)
                        report("aged", {3'd0, result.aged}, {3'd0, want.aged});
                    if (want.aged)
                        agings++;
                end
            end
            if (item_valid && item_ready)
                expected_words.push_back(sketch_update(item));
            pending = expected_words.size();
        end
    end

endmodule

// ----- dv/count_min_frequency_sketch_unit_tb.sv -----
// Testbench top for the count-min frequency sketch: drives items and config,
// randomizes back-pressure, gives the verdict; needs cms_pkg, the unit and checker.
`timescale 1ns / 100ps

module count_min_frequency_sketch_unit_tb;
    import cms_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    in_word_t    item;
    logic        result_valid;
    logic        result_ready;
    out_word_t   result;
    logic        cfg_we;
    logic        cfg_index;
    logic [19:0] cfg_data;
    int          errors;
    int          pending;
    int          results_seen;
    int          agings;
    int          items_sent;
    logic [31:0] key_pool [8][4];

    count_min_frequency_sketch_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    count_min_frequency_sketch_unit_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .results_seen(results_seen), .agings(agings)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #60ms;
        $display("count_min_frequency_sketch_unit verification failed");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // The receiver drops ready at random, with ready high in most cycles.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if ($urandom_range(99) < 70)
            result_ready <= 1'b1;
        else
            result_ready <= ($urandom_range(99) < 10) ? 1'b0 : 1'($urandom_range(1));
    end

    task automatic send_word(logic op, logic [31:0] w0, logic [31:0] w1,
                             logic [31:0] w2, logic [31:0] w3, bit steady);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item <= '{operation: op, key_word0: w0, key_word1: w1, key_word2: w2, key_word3: w3};
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [19:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic pool_word(logic op, int k, bit steady);
        send_word(op, key_pool[k][0], key_pool[k][1], key_pool[k][2], key_pool[k][3], steady);
    endtask

    task automatic random_phase(int count);
        bit steady;
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
                steady = ($urandom_range(3) == 0);
            if ($urandom_range(99) < 70)
                pool_word(1'($urandom_range(1)), $urandom_range(7), steady);
            else
                send_word(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom,
                          steady);
            // Once per phase the sender waits for the pipeline to empty.
            if (n == count / 2)
            begin
                @(negedge clk);
                item_valid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
        end
    endtask

    initial
    begin
        logic [3:0] widths [8];
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_WIDTH_LOG2;
        cfg_data = '0;
        items_sent = 0;
        widths = '{4'd10, 4'd14, 4'd0, 4'd12, 4'd15, 4'd11, 4'd9, 4'd13};
        for (int k = 0; k < 8; k++)
            for (int j = 0; j < 4; j++)
                key_pool[k][j] = (k == 0) ? 32'h0 : (k == 1) ? 32'hffffffff : $urandom;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Extreme keys, then one key pushed into saturation.
        pool_word(OP_ESTIMATE, 0, 0);
        pool_word(OP_RECORD, 0, 0);
        pool_word(OP_RECORD, 1, 0);
        pool_word(OP_ESTIMATE, 0, 0);
        pool_word(OP_ESTIMATE, 1, 0);
        repeat (16) pool_word(OP_RECORD, 2, 0);
        pool_word(OP_ESTIMATE, 2, 0);
        drain();

        // Zero and unit thresholds age on every record.
        write_reg(CFG_AGING_THRESHOLD, 20'd0);
        pool_word(OP_RECORD, 2, 0);
        pool_word(OP_ESTIMATE, 2, 0);
        drain();
        write_reg(CFG_AGING_THRESHOLD, 20'd1);
        pool_word(OP_RECORD, 3, 0);
        pool_word(OP_ESTIMATE, 2, 0);
        drain();

        // Highest threshold, then lowered below the count so the next record ages.
        write_reg(CFG_AGING_THRESHOLD, 20'hfffff);
        repeat (6) pool_word(OP_RECORD, 4, 0);
        drain();
        write_reg(CFG_AGING_THRESHOLD, 20'd3);
        pool_word(OP_RECORD, 4, 0);
        pool_word(OP_ESTIMATE, 4, 0);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            write_reg(CFG_WIDTH_LOG2, {16'd0, widths[p]});
            write_reg(CFG_AGING_THRESHOLD, (p == 3) ? 20'hfffff : 20'($urandom_range(400, 100)));
            random_phase(250);
            drain();
        end

        $display("%0d items sent over eight widths (out-of-range ones included) and", items_sent);
        $display("thresholds from zero to maximum; %0d results checked, %0d of them aging",
                 results_seen, agings);
        if (errors == 0)
            $display("count_min_frequency_sketch_unit verification clean");
        else
            $display("count_min_frequency_sketch_unit verification failed");
        $finish;
    end

endmodule
